// File: rtl/dabuf_pkg.sv
// ----------------------------------------------------------------------------
// dabuf_pkg
// Shared constants and types of the deadline aware aggregation buffer.
// ----------------------------------------------------------------------------
package dabuf_pkg;

	localparam int GATEWAYS    = 4;
	localparam int QUEUE_DEPTH = 32;
	localparam int GW_W        = 2;
	localparam int HANDLE_W    = 16;
	localparam int TIME_W      = 32;
	localparam int RATE_W      = 8;
	localparam int THR_W       = 6;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W     = HANDLE_W + TIME_W;
	localparam int ADDR_W      = GW_W + IDX_W;
	localparam int MEM_DEPTH   = 2 ** ADDR_W;
	localparam int USEC_W      = 20;
	localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

	localparam logic [1:0] REG_RATE      = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_CUTOFF    = 2'd2;
	localparam logic [1:0] REG_FLUSH_ALL = 2'd3;

	localparam logic [RATE_W-1:0] RATE_RST      = 8'd2;
	localparam logic [THR_W-1:0]  THRESHOLD_RST = 6'd16;
	localparam logic [TIME_W-1:0] CUTOFF_RST    = 32'd48500000;
	localparam logic [TIME_W-1:0] FLUSH_ALL_RST = 32'd18900000;

	typedef struct packed {
		logic              done;
		logic [FILL_W-1:0] quot;
	} div_res_t;

endpackage

// File: rtl/dabuf_ram.sv
// ----------------------------------------------------------------------------
// dabuf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dabuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/dabuf_div.sv
// ----------------------------------------------------------------------------
// dabuf_div
// Iterative restoring divider, one quotient bit per cycle, fill by rate.
// ----------------------------------------------------------------------------
module dabuf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dabuf_pkg::FILL_W-1:0]  dividend,
	input  logic [dabuf_pkg::RATE_W-1:0]  divisor,
	output dabuf_pkg::div_res_t           res
);

	logic                         busy_q;
	logic [dabuf_pkg::FILL_W-1:0] cnt_q;
	logic [dabuf_pkg::FILL_W-1:0] dvd_q;
	logic [dabuf_pkg::RATE_W-1:0] dvs_q;
	logic [dabuf_pkg::RATE_W-1:0] rem_q;
	logic [dabuf_pkg::RATE_W:0]   rem_sh;
	logic                         ge;

	assign rem_sh = {rem_q, dvd_q[dabuf_pkg::FILL_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= dabuf_pkg::FILL_W[dabuf_pkg::FILL_W-1:0];
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= (divisor == '0) ? dabuf_pkg::RATE_W'(1) : divisor;
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? dabuf_pkg::RATE_W'(rem_sh - {1'b0, dvs_q})
				: rem_sh[dabuf_pkg::RATE_W-1:0];
			dvd_q <= {dvd_q[dabuf_pkg::FILL_W-2:0], ge};
		end
	end

	assign res.done = busy_q && cnt_q == '0;
	assign res.quot = dvd_q;

endmodule

// File: rtl/deadline_aware_aggregation_buffer.sv
// ----------------------------------------------------------------------------
// deadline_aware_aggregation_buffer
// Per gateway packet queues with expiry purge and deadline driven flushing.
// ----------------------------------------------------------------------------
// Packets enter on the s_ stream (gateway, handle, deadline, now) and one
// result per dropped or forwarded packet leaves on the m_ stream; m_tuser is
// the disposition (0 dropped, 1 forwarded) and m_tlast marks the final result
// of one input. Registers are written on the cfg_ channel, which is always
// ready. The user must write registers only while the block is idle; the
// block itself does not enforce it. After the accept cycle an item goes
// through divide, scale, a scan of the queue and the decision; a flush-all
// skips these steps. A drop pass, when taken, reads each queued entry once;
// the new packet is then either sent, followed by a forward pass over the
// queued entries, or enqueued. The walks over the shared queue RAM, one read
// per entry and step, set how long an item takes; s_tready is low for the
// whole time, so a new packet is accepted only once the last one is done.
// Reset clears the fill counts and loads the register defaults; queue RAM is
// not cleared, entries above the fill are never read.
// A stalled receiver holds the result in the output register and the
// sequencer waits on it without losing or repeating results.
// ----------------------------------------------------------------------------
module deadline_aware_aggregation_buffer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // gateway, packet_handle, deadline, now
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_gateway, out_handle
	output logic        m_tuser,   // disposition
	output logic        m_tlast,   // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_MUL  = 4'd2;
	localparam logic [3:0] ST_P1   = 4'd3;
	localparam logic [3:0] ST_DEC  = 4'd4;
	localparam logic [3:0] ST_P2R  = 4'd5;
	localparam logic [3:0] ST_P2P  = 4'd6;
	localparam logic [3:0] ST_NEWF = 4'd7;
	localparam logic [3:0] ST_P3R  = 4'd8;
	localparam logic [3:0] ST_P3P  = 4'd9;
	localparam logic [3:0] ST_ENQ  = 4'd10;

	localparam int FW  = dabuf_pkg::FILL_W;
	localparam int TW  = dabuf_pkg::TIME_W;
	localparam int HW  = dabuf_pkg::HANDLE_W;
	localparam int GWW = dabuf_pkg::GW_W;

	logic [3:0] state_q;

	logic [dabuf_pkg::RATE_W-1:0] rate_q;
	logic [dabuf_pkg::THR_W-1:0]  thr_q;
	logic [TW-1:0]                cutoff_q;
	logic [TW-1:0]                flush_all_q;

	logic [FW-1:0] fill_q [dabuf_pkg::GATEWAYS];

	logic [GWW-1:0] gw_q;
	logic [HW-1:0]  handle_q;
	logic [TW-1:0]  dl_q;
	logic [TW-1:0]  now_q;
	logic [FW-1:0]  fill_lat_q;
	logic [TW:0]    horizon_q;
	logic           purge_q;
	logic           flush_q;
	logic [FW-1:0]  idx_q;
	logic           rv_s1;
	logic [FW-1:0]  drops_q;
	logic [FW-1:0]  near_q;
	logic [FW-1:0]  drop_cnt_q;
	logic [FW-1:0]  wr_ptr_q;
	logic [FW-1:0]  fwd_q;

	logic           m_tvalid_q;
	logic [GWW-1:0] m_gw_q;
	logic [HW-1:0]  m_handle_q;
	logic           m_disp_q;
	logic           m_last_q;

	logic [GWW-1:0] in_gw;
	logic [HW-1:0]  in_handle;
	logic [TW-1:0]  in_dl;
	logic [TW-1:0]  in_now;
	logic           in_xfer;
	logic           in_range;

	logic                          div_start;
	dabuf_pkg::div_res_t           div_res;
	logic                          can_load;
	logic [dabuf_pkg::ENTRY_W-1:0] rd_data;
	logic [TW-1:0]                 rd_dl;
	logic [HW-1:0]                 rd_hd;
	logic                          expired;
	logic [FW-1:0]                 kept_cnt;
	logic                          flush_d;
	logic                          p1_issue;

	logic                          mem_we;
	logic [dabuf_pkg::ADDR_W-1:0]  mem_waddr;
	logic [dabuf_pkg::ENTRY_W-1:0] mem_wdata;
	logic                          mem_re;
	logic [dabuf_pkg::ADDR_W-1:0]  mem_raddr;

	logic          emit_en;
	logic [HW-1:0] emit_handle;
	logic          emit_disp;
	logic          emit_last;

	assign in_gw     = s_tdata[1:0];
	assign in_handle = s_tdata[17:2];
	assign in_dl     = s_tdata[49:18];
	assign in_now    = s_tdata[81:50];

	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign in_range  = 32'(in_gw) < dabuf_pkg::GATEWAYS;
	assign div_start = in_xfer && in_range && !(in_now > flush_all_q);

	assign rd_dl    = rd_data[TW-1:0];
	assign rd_hd    = rd_data[dabuf_pkg::ENTRY_W-1:TW];
	assign expired  = purge_q && (rd_dl < now_q);
	assign kept_cnt = fill_lat_q - drops_q;
	assign can_load = !m_tvalid_q || m_tready;
	assign p1_issue = (state_q == ST_P1) && (idx_q < fill_lat_q);
	assign flush_d  = ({{(FW - dabuf_pkg::THR_W){1'b0}}, thr_q} <= near_q)
		|| (now_q > cutoff_q) || (32'(kept_cnt) >= dabuf_pkg::QUEUE_DEPTH);

	assign mem_re    = p1_issue || state_q == ST_P2R || state_q == ST_P3R;
	assign mem_raddr = {gw_q, idx_q[dabuf_pkg::IDX_W-1:0]};
	assign mem_we    = (state_q == ST_P2P && !expired && !flush_q) || state_q == ST_ENQ;
	assign mem_waddr = (state_q == ST_ENQ) ? {gw_q, kept_cnt[dabuf_pkg::IDX_W-1:0]}
		: {gw_q, wr_ptr_q[dabuf_pkg::IDX_W-1:0]};
	assign mem_wdata = (state_q == ST_ENQ) ? {handle_q, dl_q} : rd_data;

	dabuf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (fill_q[in_gw]),
		.divisor  (rate_q),
		.res      (div_res)
	);

	dabuf_ram #(
		.WIDTH (dabuf_pkg::ENTRY_W),
		.DEPTH (dabuf_pkg::MEM_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (rd_data)
	);

	always_comb begin
		emit_en     = 1'b0;
		emit_handle = rd_hd;
		emit_disp   = 1'b0;
		emit_last   = 1'b0;
		unique case (state_q)
			ST_P2P: begin
				emit_en   = expired && can_load;
				emit_last = (drop_cnt_q == drops_q - 1'b1) && !flush_q;
			end
			ST_NEWF: begin
				emit_en     = can_load;
				emit_handle = handle_q;
				emit_disp   = 1'b1;
				emit_last   = kept_cnt == '0;
			end
			ST_P3P: begin
				emit_en   = !expired && can_load;
				emit_disp = 1'b1;
				emit_last = fwd_q == kept_cnt - 1'b1;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= dabuf_pkg::RATE_RST;
			thr_q       <= dabuf_pkg::THRESHOLD_RST;
			cutoff_q    <= dabuf_pkg::CUTOFF_RST;
			flush_all_q <= dabuf_pkg::FLUSH_ALL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dabuf_pkg::REG_RATE:      rate_q      <= cfg_data[dabuf_pkg::RATE_W-1:0];
				dabuf_pkg::REG_THRESHOLD: thr_q       <= cfg_data[dabuf_pkg::THR_W-1:0];
				dabuf_pkg::REG_CUTOFF:    cutoff_q    <= cfg_data;
				dabuf_pkg::REG_FLUSH_ALL: flush_all_q <= cfg_data;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			m_gw_q     <= gw_q;
			m_handle_q <= emit_handle;
			m_disp_q   <= emit_disp;
			m_last_q   <= emit_last;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int g = 0; g < dabuf_pkg::GATEWAYS; g++) begin
				fill_q[g] <= '0;
			end
			idx_q      <= '0;
			rv_s1      <= 1'b0;
			drops_q    <= '0;
			near_q     <= '0;
			drop_cnt_q <= '0;
			wr_ptr_q   <= '0;
			fwd_q      <= '0;
			purge_q    <= 1'b0;
			flush_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q      <= '0;
					rv_s1      <= 1'b0;
					drops_q    <= '0;
					near_q     <= '0;
					drop_cnt_q <= '0;
					wr_ptr_q   <= '0;
					fwd_q      <= '0;
					purge_q    <= 1'b1;
					flush_q    <= 1'b0;
					if (in_xfer && in_range) begin
						if (in_now > flush_all_q) begin
							purge_q <= 1'b0;
							flush_q <= 1'b1;
							state_q <= ST_NEWF;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_P1;
				end
				ST_P1: begin
					if (p1_issue) begin
						idx_q <= idx_q + 1'b1;
					end
					rv_s1 <= p1_issue;
					if (rv_s1) begin
						if (rd_dl < now_q) begin
							drops_q <= drops_q + 1'b1;
						end else if ({1'b0, rd_dl} < horizon_q) begin
							near_q <= near_q + 1'b1;
						end
					end
					if (!p1_issue && !rv_s1) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					flush_q <= flush_d;
					idx_q   <= '0;
					if (drops_q != '0) begin
						state_q <= ST_P2R;
					end else if (flush_d) begin
						state_q <= ST_NEWF;
					end else begin
						state_q <= ST_ENQ;
					end
				end
				ST_P2R: begin
					state_q <= ST_P2P;
				end
				ST_P2P: begin
					if (!expired || can_load) begin
						idx_q <= idx_q + 1'b1;
						if (expired) begin
							drop_cnt_q <= drop_cnt_q + 1'b1;
						end else begin
							wr_ptr_q <= wr_ptr_q + 1'b1;
						end
						if (idx_q + 1'b1 == fill_lat_q) begin
							state_q <= flush_q ? ST_NEWF : ST_ENQ;
						end else begin
							state_q <= ST_P2R;
						end
					end
				end
				ST_NEWF: begin
					if (can_load) begin
						idx_q <= '0;
						fwd_q <= '0;
						if (kept_cnt == '0) begin
							fill_q[gw_q] <= '0;
							state_q      <= ST_IDLE;
						end else begin
							state_q <= ST_P3R;
						end
					end
				end
				ST_P3R: begin
					state_q <= ST_P3P;
				end
				ST_P3P: begin
					if (expired || can_load) begin
						idx_q <= idx_q + 1'b1;
						if (!expired) begin
							fwd_q <= fwd_q + 1'b1;
						end
						if (idx_q + 1'b1 == fill_lat_q) begin
							fill_q[gw_q] <= '0;
							state_q      <= ST_IDLE;
						end else begin
							state_q <= ST_P3R;
						end
					end
				end
				ST_ENQ: begin
					fill_q[gw_q] <= kept_cnt + 1'b1;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			gw_q       <= in_gw;
			handle_q   <= in_handle;
			dl_q       <= in_dl;
			now_q      <= in_now;
			fill_lat_q <= fill_q[in_gw];
		end
		if (state_q == ST_MUL) begin
			horizon_q <= {1'b0, now_q}
				+ (TW + 1)'(div_res.quot) * (TW + 1)'(dabuf_pkg::USEC_PER_SEC);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, m_handle_q, m_gw_q};
	assign m_tuser  = m_disp_q;
	assign m_tlast  = m_last_q;

	a_compact_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P2P) |-> (wr_ptr_q <= idx_q))
		else $error("compaction write ran ahead of the read index");

	a_drops_before_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEWF) |-> (drop_cnt_q == drops_q))
		else $error("forward started before all drops were sent");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENQ) |-> (32'(kept_cnt) < dabuf_pkg::QUEUE_DEPTH))
		else $error("enqueue into a full queue");

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> !(m_tvalid && $rose(m_tvalid)) || $past(state_q) != ST_IDLE)
		else $error("result produced while idle");

endmodule
